// ----- rtl/jsc_pkg.sv -----
// ----------------------------------------------------------------------------
// jsc_pkg
// Shared types, register indexes and fixed-point helpers of the joint servo.
// ----------------------------------------------------------------------------
package jsc_pkg;

    localparam int DATA_W  = 32;        // Q16.16 word
    localparam int GAIN_W  = 31;        // unsigned gains and bounds
    localparam int CALC_W  = 65;        // wide compare width for clamping
    localparam int FRAC_W  = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [DATA_W-1:0] PI_Q16      = 32'sd205887;
    localparam logic signed [DATA_W-1:0] VEL_ERR_MAX = 32'sd655360;
    localparam logic signed [DATA_W-1:0] Q_MIN       = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX       = 32'sh7FFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT   = 3'd7;

    typedef enum logic [1:0] {
        MODE_POSITION  = 2'd0,
        MODE_VELOCITY  = 2'd1,
        MODE_TORQUE    = 2'd2,
        MODE_KINEMATIC = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              control_mode;
        logic [GAIN_W-1:0]  position_gain;
        logic [GAIN_W-1:0]  damping_gain;
        logic [GAIN_W-1:0]  velocity_gain;
        logic [GAIN_W-1:0]  torque_limit;
        logic [DATA_W-1:0]  lower_limit;
        logic [DATA_W-1:0]  upper_limit;
        logic [GAIN_W-1:0]  speed_limit;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0]  measured_position;
        logic [DATA_W-1:0]  measured_velocity;
        logic [DATA_W-1:0]  target_position;
        logic [DATA_W-1:0]  target_velocity;
        logic [DATA_W-1:0]  target_torque;
        logic [GAIN_W-1:0]  time_step;
    } tick_t;

    typedef struct packed {
        logic [DATA_W-1:0]  drive;
        logic [DATA_W-1:0]  position_out;
        logic [DATA_W-1:0]  velocity_out;
    } result_t;

    // Saturate a wide signed value into [lo, hi].
    function automatic logic [DATA_W-1:0] clamp_wide(
        input logic signed [CALC_W-1:0] v,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        logic signed [CALC_W-1:0] lo_w;
        logic signed [CALC_W-1:0] hi_w;
        lo_w = CALC_W'(lo);
        hi_w = CALC_W'(hi);
        if (v < lo_w)
            return lo;
        else if (v > hi_w)
            return hi;
        else
            return DATA_W'(v);
    endfunction

endpackage

// ----- rtl/jsc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// jsc_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module jsc_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [jsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jsc_pkg::DATA_W-1:0]     cfg_data,
    output jsc_pkg::cfg_t                  cfg
);
    import jsc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CONTROL_MODE:  cfg_next.control_mode  = mode_t'(cfg_data[1:0]);
                CFG_POSITION_GAIN: cfg_next.position_gain = cfg_data[GAIN_W-1:0];
                CFG_DAMPING_GAIN:  cfg_next.damping_gain  = cfg_data[GAIN_W-1:0];
                CFG_VELOCITY_GAIN: cfg_next.velocity_gain = cfg_data[GAIN_W-1:0];
                CFG_TORQUE_LIMIT:  cfg_next.torque_limit  = cfg_data[GAIN_W-1:0];
                CFG_LOWER_LIMIT:   cfg_next.lower_limit   = cfg_data;
                CFG_UPPER_LIMIT:   cfg_next.upper_limit   = cfg_data;
                CFG_SPEED_LIMIT:   cfg_next.speed_limit   = cfg_data[GAIN_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/jsc_servo_core.sv -----
// ----------------------------------------------------------------------------
// jsc_servo_core
// Single-pass servo math: target clamping, PD / P / torque / kinematic modes.
// ----------------------------------------------------------------------------
module jsc_servo_core
(
    input  jsc_pkg::tick_t                 tick,
    input  jsc_pkg::cfg_t                  cfg,
    input  logic [jsc_pkg::DATA_W-1:0]     kin_pos,
    output jsc_pkg::result_t               res,
    output logic                           kin_update,
    output logic [jsc_pkg::DATA_W-1:0]     kin_pos_next
);
    import jsc_pkg::*;

    logic signed [DATA_W-1:0] mp, mv, tp_raw, tp, tv_raw, tv, tt;
    logic signed [DATA_W-1:0] lo, hi, tl, spd, kin_base;
    logic                     pos_active;
    logic signed [DATA_W:0]   ep_full, dneg, ev;
    logic signed [18:0]       ep;
    logic signed [20:0]       dv;
    logic signed [50:0]       prod_p;
    logic signed [52:0]       prod_d;
    logic signed [53:0]       pd_sum;
    logic signed [63:0]       prod_v;
    logic signed [63:0]       prod_k;
    logic signed [47:0]       k_sum;
    logic signed [DATA_W-1:0] k_sat, k_new;
    logic [DATA_W-1:0]        drive_pos, drive_vel;

    always_comb
    begin
        mp     = $signed(tick.measured_position);
        mv     = $signed(tick.measured_velocity);
        tp_raw = $signed(tick.target_position);
        tv_raw = $signed(tick.target_velocity);
        lo     = $signed(cfg.lower_limit);
        hi     = $signed(cfg.upper_limit);
        tl     = $signed({1'b0, cfg.torque_limit});
        spd    = $signed({1'b0, cfg.speed_limit});

        // Position limits only act when the window is well formed.
        pos_active = lo < hi;
        tp = pos_active ? $signed(clamp_wide(CALC_W'(tp_raw), lo, hi)) : tp_raw;
        tv = (spd != '0) ? $signed(clamp_wide(CALC_W'(tv_raw), -spd, spd)) : tv_raw;
        tt = $signed(clamp_wide(CALC_W'($signed(tick.target_torque)), -tl, tl));

        // Position PD
        ep_full = (DATA_W+1)'(tp) - (DATA_W+1)'(mp);
        if (ep_full > (DATA_W+1)'(PI_Q16))
            ep = 19'(PI_Q16);
        else if (ep_full < -(DATA_W+1)'(PI_Q16))
            ep = -19'(PI_Q16);
        else
            ep = 19'(ep_full);

        dneg = -(DATA_W+1)'(mv);
        if (dneg > (DATA_W+1)'(VEL_ERR_MAX))
            dv = 21'(VEL_ERR_MAX);
        else if (dneg < -(DATA_W+1)'(VEL_ERR_MAX))
            dv = -21'(VEL_ERR_MAX);
        else
            dv = 21'(dneg);

        prod_p    = 51'($signed({1'b0, cfg.position_gain})) * 51'(ep);
        prod_d    = 53'($signed({1'b0, cfg.damping_gain})) * 53'(dv);
        pd_sum    = 54'(prod_p) + 54'(prod_d);
        drive_pos = clamp_wide(CALC_W'(pd_sum >>> FRAC_W), -tl, tl);

        // Velocity P: exact product, so saturation falls out of the clamp
        ev        = (DATA_W+1)'(tv) - (DATA_W+1)'(mv);
        prod_v    = 64'($signed({1'b0, cfg.velocity_gain})) * 64'(ev);
        drive_vel = clamp_wide(CALC_W'(prod_v >>> FRAC_W), -tl, tl);

        // Kinematic integration; seed from the sensor when the state is empty
        kin_base = ($signed(kin_pos) == '0 && mp != '0) ? mp : $signed(kin_pos);
        prod_k   = 64'(tv) * 64'($signed({1'b0, tick.time_step}));
        k_sum    = 48'(kin_base) + 48'(prod_k >>> FRAC_W);
        k_sat    = $signed(clamp_wide(CALC_W'(k_sum), Q_MIN, Q_MAX));
        k_new    = pos_active ? $signed(clamp_wide(CALC_W'(k_sat), lo, hi)) : k_sat;
    end

    always_comb
    begin
        res.drive        = '0;
        res.position_out = tick.measured_position;
        res.velocity_out = tick.measured_velocity;
        kin_update       = 1'b0;
        kin_pos_next     = kin_pos;
        unique case (cfg.control_mode)
            MODE_POSITION:  res.drive = drive_pos;
            MODE_VELOCITY:  res.drive = drive_vel;
            MODE_TORQUE:    res.drive = tt;
            MODE_KINEMATIC:
            begin
                kin_update = 1'b1;
                if (tv != '0)
                begin
                    kin_pos_next     = k_new;
                    res.position_out = k_new;
                    res.velocity_out = tv;
                end
                else
                begin
                    kin_pos_next     = tp;
                    res.position_out = tp;
                    res.velocity_out = '0;
                end
            end
            default:        res.drive = '0;
        endcase
    end

endmodule

// ----- rtl/joint_servo_controller_top.sv -----
// ----------------------------------------------------------------------------
// joint_servo_controller_top
// Joint servo controller, one control tick per request, signed Q16.16.
// ----------------------------------------------------------------------------
// Takes one tick request per clock while in_stall is low and returns one result
// per tick: the request lands in an input register, the servo math
// (four multipliers of up to 32 by 33 bits working in parallel, then add and
// clamp) runs in the following cycle, the answer is loaded into the result
// register once it is empty or being drained and is held there until the
// consumer takes it. The kinematic position state updates as the result is
// loaded, so consecutive ticks chain without bubbles. in_stall rises only when
// both registers are full and out_stall is high. Write configuration only while
// no tick is in flight; no clearing pass follows reset.
module joint_servo_controller_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [jsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jsc_pkg::DATA_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [jsc_pkg::DATA_W-1:0]     measured_position,
    input  logic [jsc_pkg::DATA_W-1:0]     measured_velocity,
    input  logic [jsc_pkg::DATA_W-1:0]     target_position,
    input  logic [jsc_pkg::DATA_W-1:0]     target_velocity,
    input  logic [jsc_pkg::DATA_W-1:0]     target_torque,
    input  logic [jsc_pkg::GAIN_W-1:0]     time_step,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [jsc_pkg::DATA_W-1:0]     drive,
    output logic [jsc_pkg::DATA_W-1:0]     position_out,
    output logic [jsc_pkg::DATA_W-1:0]     velocity_out
);
    import jsc_pkg::*;

    cfg_t              cfg;
    tick_t             tick_reg, tick_next;
    logic              s1_valid_reg, s1_valid_next;
    result_t           res_reg, res_next, core_res;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] kin_pos_reg, kin_pos_next, core_kin_next;
    logic              core_kin_update;
    logic              s2_load, s1_take;

    jsc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    jsc_servo_core u_core
    (
        .tick         (tick_reg),
        .cfg          (cfg),
        .kin_pos      (kin_pos_reg),
        .res          (core_res),
        .kin_update   (core_kin_update),
        .kin_pos_next (core_kin_next)
    );

    // Advance into the result register whenever it is empty or being drained.
    assign s2_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s2_load;
    assign s1_take  = in_valid && !in_stall;

    always_comb
    begin
        tick_next     = tick_reg;
        s1_valid_next = s1_valid_reg;
        if (s1_take)
        begin
            tick_next.measured_position = measured_position;
            tick_next.measured_velocity = measured_velocity;
            tick_next.target_position   = target_position;
            tick_next.target_velocity   = target_velocity;
            tick_next.target_torque     = target_torque;
            tick_next.time_step         = time_step;
            s1_valid_next               = 1'b1;
        end
        else if (s2_load)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        kin_pos_next   = kin_pos_reg;
        if (s2_load)
        begin
            res_next       = core_res;
            out_valid_next = 1'b1;
            if (core_kin_update)
                kin_pos_next = core_kin_next;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            kin_pos_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            kin_pos_reg   <= kin_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg <= tick_next;
        res_reg  <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign drive        = res_reg.drive;
    assign position_out = res_reg.position_out;
    assign velocity_out = res_reg.velocity_out;

endmodule

// ----- rtl/jsc_checker.sv -----
// ----------------------------------------------------------------------------
// jsc_checker
// Port-level checks of the joint servo handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module jsc_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [jsc_pkg::DATA_W-1:0] drive,
    input  logic [jsc_pkg::DATA_W-1:0] position_out,
    input  logic [jsc_pkg::DATA_W-1:0] velocity_out
);
    import jsc_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive)
            && $stable(position_out) && $stable(velocity_out))
        else $error("stalled result changed");

    // Never push back while the result register is empty.
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // Push back only under a downstream stall.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    // An accepted request reaches the output once the consumer drains.
    a_request_flows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall |=> out_valid)
        else $error("accepted request did not reach output");

endmodule

bind joint_servo_controller_top jsc_checker u_jsc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .drive        (drive),
    .position_out (position_out),
    .velocity_out (velocity_out)
);

// ----- sim/joint_servo_controller_top_tb.sv -----
// ----------------------------------------------------------------------------
// joint_servo_controller_top_tb
// Self-checking bench for the joint servo: directed corner ticks, then
// random ticks over many register settings. Both handshakes idle at random,
// and every result is checked field by field against a servo predictor.
// ----------------------------------------------------------------------------
module joint_servo_controller_top_tb;

    import jsc_pkg::*;

    localparam int ONE = 65536;     // 1.0 in Q16.16

    // ------------------------------------------------------------------------
    // Expected-result store and servo predictor
    // ------------------------------------------------------------------------
    class servo_checker;
        mode_t      mode;
        longint     kp;
        longint     kd;
        longint     kv;
        longint     tlim;
        longint     lo_lim;
        longint     hi_lim;
        longint     vlim;
        longint     kin_pos;
        result_t    pending_results[$];
        int         errors;

        function new();
            mode    = MODE_POSITION;
            kp      = 0;
            kd      = 0;
            kv      = 0;
            tlim    = 0;
            lo_lim  = 0;
            hi_lim  = 0;
            vlim    = 0;
            kin_pos = 0;
            errors  = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                CFG_CONTROL_MODE:  mode   = mode_t'(data[1:0]);
                CFG_POSITION_GAIN: kp     = data[GAIN_W-1:0];
                CFG_DAMPING_GAIN:  kd     = data[GAIN_W-1:0];
                CFG_VELOCITY_GAIN: kv     = data[GAIN_W-1:0];
                CFG_TORQUE_LIMIT:  tlim   = data[GAIN_W-1:0];
                CFG_LOWER_LIMIT:   lo_lim = $signed(data);
                CFG_UPPER_LIMIT:   hi_lim = $signed(data);
                CFG_SPEED_LIMIT:   vlim   = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function longint limit_position(longint p);
            return (lo_lim < hi_lim) ? clip(p, lo_lim, hi_lim) : p;
        endfunction

        function result_t servo_tick(tick_t t);
            longint             mp;
            longint             mv;
            longint             tp;
            longint             tv;
            longint             tt;
            longint             dt;
            longint             e;
            longint             d;
            longint             s;
            longint             k;
            longint             drv;
            longint             pos;
            longint             vel;
            longint             pi_q;
            longint             vmax;
            longint             qmin;
            longint             qmax;
            longint unsigned    mag;
            longint unsigned    ukv;
            result_t            r;
            mp   = $signed(t.measured_position);
            mv   = $signed(t.measured_velocity);
            tp   = limit_position($signed(t.target_position));
            tv   = $signed(t.target_velocity);
            tt   = $signed(t.target_torque);
            dt   = t.time_step;
            pi_q = PI_Q16;
            vmax = VEL_ERR_MAX;
            qmin = Q_MIN;
            qmax = Q_MAX;
            drv  = 0;
            pos  = mp;
            vel  = mv;
            if (vlim > 0)
                tv = clip(tv, -vlim, vlim);
            tt = clip(tt, -tlim, tlim);
            case (mode)
                MODE_POSITION: begin
                    e   = clip(tp - mp, -pi_q, pi_q);
                    d   = clip(-mv, -vmax, vmax);
                    s   = (kp * e + kd * d) >>> FRAC_W;
                    drv = clip(s, -tlim, tlim);
                end
                MODE_VELOCITY: begin
                    e   = tv - mv;
                    mag = (e < 0) ? -e : e;
                    ukv = kv;
                    // saturate instead of forming a product past 47 bits
                    if (mag != 0 && ukv > (64'd1 << 47) / mag)
                        drv = (e < 0) ? -tlim : tlim;
                    else
                        drv = clip((kv * e) >>> FRAC_W, -tlim, tlim);
                end
                MODE_TORQUE: drv = tt;
                default: begin
                    if (tv != 0) begin
                        if (kin_pos == 0 && mp != 0)
                            kin_pos = mp;
                        k       = kin_pos + ((tv * dt) >>> FRAC_W);
                        kin_pos = limit_position(clip(k, qmin, qmax));
                        pos     = kin_pos;
                        vel     = tv;
                    end
                    else begin
                        kin_pos = tp;
                        pos     = tp;
                        vel     = 0;
                    end
                    drv = 0;
                end
            endcase
            r.drive        = 32'(drv);
            r.position_out = 32'(pos);
            r.velocity_out = 32'(vel);
            return r;
        endfunction

        function void note_request(tick_t t);
            pending_results.push_back(servo_tick(t));
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_result(logic [DATA_W-1:0] drv, logic [DATA_W-1:0] pos,
                          logic [DATA_W-1:0] vel);
            result_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result with no tick pending, drive %h", drv));
                return;
            end
            want = pending_results.pop_front();
            if (drv !== want.drive)
                report($sformatf("drive %h, want %h", drv, want.drive));
            if (pos !== want.position_out)
                report($sformatf("position_out %h, want %h", pos, want.position_out));
            if (vel !== want.velocity_out)
                report($sformatf("velocity_out %h, want %h", vel, want.velocity_out));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                   clk               = 1'b0;
    logic                   rst_n             = 1'b0;
    logic                   cfg_we            = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index         = '0;
    logic [DATA_W-1:0]      cfg_data          = '0;
    logic                   in_valid          = 1'b0;
    logic                   in_stall;
    logic [DATA_W-1:0]      measured_position = '0;
    logic [DATA_W-1:0]      measured_velocity = '0;
    logic [DATA_W-1:0]      target_position   = '0;
    logic [DATA_W-1:0]      target_velocity   = '0;
    logic [DATA_W-1:0]      target_torque     = '0;
    logic [GAIN_W-1:0]      time_step         = '0;
    logic                   out_valid;
    logic                   out_stall         = 1'b0;
    logic [DATA_W-1:0]      drive;
    logic [DATA_W-1:0]      position_out;
    logic [DATA_W-1:0]      velocity_out;

    servo_checker           sb = new();
    int                     sent_count = 0;

    always #6 clk = ~clk;

    joint_servo_controller_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .measured_position (measured_position),
        .measured_velocity (measured_velocity),
        .target_position   (target_position),
        .target_velocity   (target_velocity),
        .target_torque     (target_torque),
        .time_step         (time_step),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .drive             (drive),
        .position_out      (position_out),
        .velocity_out      (velocity_out)
    );

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    // no idling at all while this window of requests goes through
    function automatic bit idle_roll();
        if (sent_count >= 500 && sent_count < 760)
            return 1'b0;
        return $urandom_range(99) < 18;
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom();
            4, 5, 6:    return 32'(int'($urandom_range(0, 16 * ONE)) - 8 * ONE);
            7, 8:       return 32'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
            default: begin
                case ($urandom_range(4))
                    0:       return Q_MIN;
                    1:       return Q_MAX;
                    2:       return '0;
                    3:       return 32'd1;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] nudge();
        return 32'(int'($urandom_range(0, 2 * ONE)) - ONE);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3:    return 31'($urandom());
            default: return 31'($urandom_range(0, 64 * ONE));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_bound();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 31'($urandom());
            default: return 31'($urandom_range(1, 200 * ONE));
        endcase
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        t.measured_position = rand_word();
        t.measured_velocity = rand_word();
        // keep targets near the measurement half the time so the loops work
        // inside their clamps
        t.target_position = $urandom_range(1) ? t.measured_position + nudge() : rand_word();
        t.target_velocity = $urandom_range(1) ? t.measured_velocity + nudge() : rand_word();
        t.target_torque   = rand_word();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: t.time_step = 31'($urandom_range(0, 6554));
            7, 8:                t.time_step = 31'($urandom());
            default:             t.time_step = $urandom_range(1) ? '1 : '0;
        endcase
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_tick(input tick_t t);
        while (idle_roll()) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        measured_position <= t.measured_position;
        measured_velocity <= t.measured_velocity;
        target_position   <= t.target_position;
        target_velocity   <= t.target_velocity;
        target_torque     <= t.target_torque;
        time_step         <= t.time_step;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(t);
        sent_count++;
    endtask

    task automatic directed_tick(input logic [DATA_W-1:0] mp, input logic [DATA_W-1:0] mv,
                                 input logic [DATA_W-1:0] tp, input logic [DATA_W-1:0] tv,
                                 input logic [DATA_W-1:0] tt, input logic [GAIN_W-1:0] dt);
        tick_t t;
        t.measured_position = mp;
        t.measured_velocity = mv;
        t.target_position   = tp;
        t.target_velocity   = tv;
        t.target_torque     = tt;
        t.time_step         = dt;
        send_tick(t);
    endtask

    // drop valid and wait until every result is back and the pipe is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_all(input mode_t m, input logic [GAIN_W-1:0] kp,
                             input logic [GAIN_W-1:0] kd, input logic [GAIN_W-1:0] kv,
                             input logic [GAIN_W-1:0] tl, input logic [DATA_W-1:0] lo,
                             input logic [DATA_W-1:0] hi, input logic [GAIN_W-1:0] vl);
        logic [DATA_W-1:0] vals [8];
        // unused upper bits carry noise; the block must ignore them
        vals[CFG_CONTROL_MODE]  = ($urandom() & ~32'h3) | 32'(m);
        vals[CFG_POSITION_GAIN] = {1'($urandom()), kp};
        vals[CFG_DAMPING_GAIN]  = {1'($urandom()), kd};
        vals[CFG_VELOCITY_GAIN] = {1'($urandom()), kv};
        vals[CFG_TORQUE_LIMIT]  = {1'($urandom()), tl};
        vals[CFG_LOWER_LIMIT]   = lo;
        vals[CFG_UPPER_LIMIT]   = hi;
        vals[CFG_SPEED_LIMIT]   = {1'($urandom()), vl};
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_register(CFG_IDX_W'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_config(input int phase);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        if (phase == 2) begin
            write_all(mode_t'($urandom_range(3)), '1, '1, '1, '1, Q_MIN, Q_MAX, '1);
            return;
        end
        if (phase == 5) begin
            write_all(mode_t'($urandom_range(3)), '0, '0, '0, '0, '0, '0, '0);
            return;
        end
        a = rand_word();
        b = rand_word();
        case ($urandom_range(3))
            0:       b = a;                                   // limits off
            1:       ;                                        // either order
            default: if ($signed(a) > $signed(b)) {a, b} = {b, a};
        endcase
        write_all(mode_t'($urandom_range(3)), pick_gain(), pick_gain(), pick_gain(),
                  pick_bound(), a, b, pick_bound());
    endtask

    // ------------------------------------------------------------------------
    // Result side: check accepted results, stall at random
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(drive, position_out, velocity_out);
        out_stall <= idle_roll();
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int phase;
        int n;
        phase = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // position loop: small error, error and derivative clamps, extremes
        write_all(MODE_POSITION, 2 * ONE, ONE / 2, 0, 50 * ONE, -2 * ONE, 2 * ONE, 3 * ONE);
        directed_tick(0, 0, ONE, 0, 0, 655);
        directed_tick(-5 * ONE, 0, ONE, 0, 0, 0);
        directed_tick(0, 20 * ONE, 0, 0, 0, 0);
        directed_tick(0, -20 * ONE, 0, 0, 0, 0);
        directed_tick(Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, '1);
        directed_tick(Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, 0);
        settle();

        // full gains, position limits off, speed limit off
        write_all(MODE_POSITION, '1, '1, '1, '1, ONE, -ONE, 0);
        directed_tick(0, 0, Q_MAX, 0, 0, 0);
        directed_tick(Q_MAX, Q_MAX, Q_MIN, 0, 0, 0);
        settle();

        // velocity loop with full gain: product saturation both ways
        write_all(MODE_VELOCITY, 0, 0, '1, 100 * ONE, 0, 0, 0);
        directed_tick(0, Q_MIN, 0, Q_MAX, 0, 0);
        directed_tick(0, Q_MAX, 0, Q_MIN, 0, 0);
        directed_tick(0, 0, 0, ONE, 0, 0);
        directed_tick(0, 0, 0, '1, 0, 0);
        settle();

        // velocity loop with the target clamped by the speed limit
        write_all(MODE_VELOCITY, 0, 0, 3 * ONE / 2, '1, 0, 0, ONE);
        directed_tick(0, 0, 0, Q_MAX, 0, 0);
        settle();

        // torque passthrough and its clamp
        write_all(MODE_TORQUE, 0, 0, 0, 10 * ONE, 0, 0, 0);
        directed_tick(0, 0, 0, 0, Q_MAX, 0);
        directed_tick(0, 0, 0, 0, Q_MIN, 0);
        directed_tick(0, 0, 0, 0, 3 * ONE, 0);
        settle();

        // zero torque limit forces zero drive
        write_all(MODE_POSITION, '1, '1, 0, 0, 0, 0, 0);
        directed_tick(0, -ONE, ONE, 0, Q_MAX, 0);
        settle();

        // kinematic: load from measurement, integrate into the limits, set
        write_all(MODE_KINEMATIC, 0, 0, 0, 10 * ONE, -10 * ONE, 10 * ONE, 5 * ONE);
        directed_tick(2 * ONE, 0, 0, ONE, 0, ONE / 2);
        directed_tick(0, 0, 0, Q_MAX, 0, '1);
        directed_tick(0, 0, 0, Q_MIN, 0, ONE);
        directed_tick(0, 0, Q_MIN, 0, 0, 0);
        settle();

        // kinematic with no limits: 32-bit saturation both ways, then reset to 0
        write_all(MODE_KINEMATIC, 0, 0, 0, '1, 0, 0, 0);
        directed_tick(0, 0, 0, Q_MAX, 0, '1);
        directed_tick(0, 0, 0, Q_MIN, 0, '1);
        directed_tick(0, 0, 0, 0, 0, 0);
        directed_tick(0, 0, 0, ONE, 0, ONE);
        settle();

        while (sent_count < 1350) begin
            random_config(phase);
            n = $urandom_range(30, 120);
            repeat (n) send_tick(random_tick());
            settle();
            phase++;
        end

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
